FILE: sv/remote_debug_packet_receiver_defines.svh
// assertion macros for the remote debug packet receiver
// used by the top level, expects clk and rst in scope
`ifndef REMOTE_DEBUG_PACKET_RECEIVER_DEFINES_SVH
`define REMOTE_DEBUG_PACKET_RECEIVER_DEFINES_SVH

// implication in the same cycle, off during reset
`define RDPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle, also checked across reset
`define RDPR_ASSERT_AFTER(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rdpr_pkg.sv
// shared types, constants and helpers of the remote debug packet receiver
// no dependencies
package rdpr_pkg;

  localparam int BUF_SIZE    = 1024;
  localparam int CNT_W       = $clog2(BUF_SIZE);
  localparam int POS_W       = 10;
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_ACK   = 8'h2B;
  localparam logic [7:0] CH_NAK   = 8'h2D;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_CSUM_HI = 2'd2,
    OP_CSUM_LO = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] ch;
  } op_t;

  // hex digit value, all ones for anything that is not a hex digit
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = 8'hFF;
    end
    return v;
  endfunction

  // reported position is the count modulo 1024
  function automatic logic [POS_W-1:0] pos_of(input logic [CNT_W-1:0] cnt);
    logic [POS_W+CNT_W-1:0] ext;
    ext = {{POS_W{1'b0}}, cnt};
    return ext[POS_W-1:0];
  endfunction

endpackage

FILE: sv/rdpr_front.sv
// front end: tracks framing phase and the buffer limit, classifies each item
// depends on rdpr_pkg
module rdpr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  output logic          in_ready,
  output logic          op_valid,
  output rdpr_pkg::op_t op,
  input  logic          op_ready
);
  import rdpr_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_DATA    = 4'b0010,
    PH_CSUM_HI = 4'b0100,
    PH_CSUM_LO = 4'b1000
  } phase_t;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W:0]   count_inc;
  logic             emit;
  logic             accept;

  assign in_ready  = op_ready;
  assign accept    = in_valid && in_ready;
  assign count_inc = {1'b0, count} + (CNT_W+1)'(1);

  always_comb begin
    phase_next = phase;
    count_next = count;
    emit       = 1'b0;
    op.opcode  = OP_START;
    op.ch      = in_byte;
    case (phase)
      PH_HUNT: begin
        if (in_byte == CH_START) begin
          emit       = 1'b1;
          count_next = '0;
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (in_byte == CH_END) begin
          phase_next = PH_CSUM_HI;
        end else begin
          emit       = 1'b1;
          op.opcode  = OP_PAYLOAD;
          count_next = count_inc[CNT_W-1:0];
          // buffer full: drop the packet quietly
          if (count_inc >= (CNT_W+1)'(BUF_SIZE - 1)) phase_next = PH_HUNT;
        end
      end
      PH_CSUM_HI: begin
        emit       = 1'b1;
        op.opcode  = OP_CSUM_HI;
        phase_next = PH_CSUM_LO;
      end
      PH_CSUM_LO: begin
        emit       = 1'b1;
        op.opcode  = OP_CSUM_LO;
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  assign op_valid = in_valid && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      count <= '0;
    end else if (accept) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

endmodule

FILE: sv/rdpr_queue.sv
// short queue of classified items between front and back end
// depends on rdpr_pkg
module rdpr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  rdpr_pkg::op_t in_op,
  output logic          in_ready,
  output logic          out_valid,
  output rdpr_pkg::op_t out_op,
  input  logic          out_ready
);
  import rdpr_pkg::*;

  op_t             mem [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr, rd_ptr;
  logic [QA_W:0]   fill;
  logic            push, pop;

  assign in_ready  = (fill != (QA_W+1)'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_op    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QA_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QA_W'(1);
      if (push && !pop) fill <= fill + (QA_W+1)'(1);
      else if (pop && !push) fill <= fill - (QA_W+1)'(1);
    end
  end

endmodule

FILE: sv/rdpr_back.sv
// back end: running sum, payload index, checksum compare and output register
// depends on rdpr_pkg
module rdpr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  input  rdpr_pkg::op_t    op,
  output logic             op_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [rdpr_pkg::POS_W-1:0] out_pos
);
  import rdpr_pkg::*;

  logic [7:0]       running_sum;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       sum_high_digit;
  logic [7:0]       sent_sum;
  logic [7:0]       hi_value;
  logic             take;
  logic             good;

  assign op_ready = !out_valid || out_ready;
  assign take     = op_valid && op_ready;
  assign hi_value = hex_value(op.ch);
  assign sent_sum = sum_high_digit + hex_value(op.ch);
  assign good     = (sent_sum == running_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      byte_count     <= '0;
      sum_high_digit <= '0;
    end else if (take) begin
      case (op.opcode)
        OP_START: begin
          running_sum <= '0;
          byte_count  <= '0;
        end
        OP_PAYLOAD: begin
          running_sum <= running_sum + op.ch;
          byte_count  <= byte_count + CNT_W'(1);
        end
        OP_CSUM_HI: sum_high_digit <= {hi_value[3:0], 4'h0};
        OP_CSUM_LO: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && (op.opcode == OP_PAYLOAD || op.opcode == OP_CSUM_LO)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && op.opcode == OP_PAYLOAD) begin
      out_kind <= KIND_BYTE;
      out_byte <= op.ch;
      out_pos  <= pos_of(byte_count);
    end else if (take && op.opcode == OP_CSUM_LO) begin
      out_kind <= good ? KIND_GOOD : KIND_BAD;
      out_byte <= good ? CH_ACK : CH_NAK;
      out_pos  <= pos_of(byte_count);
    end
  end

endmodule

FILE: sv/remote_debug_packet_receiver.sv
// top level of the remote debug packet receiver
// depends on rdpr_pkg, rdpr_front, rdpr_queue, rdpr_back and the defines header
//
// frames "$payload#hh" packets out of a stream of received serial characters
// s_* channel: one received character per item, in s_tdata[7:0]
// m_* channel: one result item per payload byte and one verdict per packet
//   kind in m_tuser: byte, packet good (ack '+'), checksum mismatch (nak '-')
//   position in m_tdata: payload index for bytes, payload length for verdicts
// bytes outside a packet, the '$' and '#' marks and the first checksum digit
// give no result; a payload reaching the buffer limit is dropped with no verdict
// throughput: one item per cycle while m_tready stays high, set by the combinational
// classify in the front end and the sum and compare in the back end
// with an empty queue an accepted item is written into the queue and then taken by
// the back end into the output register, where its result becomes valid
// reset (synchronous, rst high) returns to hunting for '$', empties the queue
// and drops any result not yet taken
// when m_tready is low the output register holds its item, the back end stops
// and the four-entry queue absorbs input until full, then s_tready falls
`include "remote_debug_packet_receiver_defines.svh"

module remote_debug_packet_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] data_byte, [17:8] position, [23:18] zero
  output logic [1:0]  m_tuser    // [1:0] kind
);
  import rdpr_pkg::*;

  // classified items from the front end into the queue
  logic       f_valid, f_ready;
  op_t        f_op;
  // queue to back end
  logic       q_valid, q_ready;
  op_t        q_op;

  logic [7:0]       out_byte;
  logic [POS_W-1:0] out_pos;

  rdpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_ready (s_tready),
    .op_valid (f_valid),
    .op       (f_op),
    .op_ready (f_ready)
  );

  rdpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_op     (f_op),
    .in_ready  (f_ready),
    .out_valid (q_valid),
    .out_op    (q_op),
    .out_ready (q_ready)
  );

  rdpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_valid),
    .op        (q_op),
    .op_ready  (q_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_byte  (out_byte),
    .out_pos   (out_pos)
  );

  assign m_tdata = {6'b0, out_pos, out_byte};

  // a verdict always carries the reply character that matches its kind
  `RDPR_ASSERT_NOW(a_verdict_char, m_tvalid && m_tuser != KIND_BYTE, (m_tuser == KIND_GOOD && m_tdata[7:0] == CH_ACK) || (m_tuser == KIND_BAD && m_tdata[7:0] == CH_NAK), "verdict kind and reply character disagree")
  // the back end only takes from the queue when it holds something
  `RDPR_ASSERT_NOW(a_no_ghost_result, !$past(q_valid) && !$past(rst), !$rose(m_tvalid), "result appeared with an empty queue")
  // reset leaves nothing queued and nothing on the output
  `RDPR_ASSERT_AFTER(a_reset_clears, rst, !m_tvalid && !q_valid && s_tready, "state left over after reset")

endmodule

FILE: sim/tb_remote_debug_packet_receiver.sv
// self-checking testbench for the remote debug packet receiver
// drives framed and broken "$payload#hh" streams and checks every result item
// against a cycle-free predictor, depends on rdpr_pkg and the receiver top level
module tb_remote_debug_packet_receiver;
  import rdpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TOTAL_ITEMS    = 1350;
  localparam int DRAIN_CYCLES   = 100;

  typedef enum logic [1:0] {
    RX_HUNT    = 2'd0,
    RX_DATA    = 2'd1,
    RX_CSUM_HI = 2'd2,
    RX_CSUM_LO = 2'd3
  } rx_phase_t;

  // how the two checksum characters of a generated packet are made
  typedef enum int {
    CS_GOOD,
    CS_WRONG,
    CS_BAD_HI,
    CS_BAD_LO,
    CS_BAD_BOTH
  } csum_style_t;

  typedef struct {
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic [POS_W-1:0] position;
  } rx_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  remote_debug_packet_receiver u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // predicted receiver state
  rx_phase_t  rx_phase;
  logic [7:0] rx_sum;
  int         rx_count;
  logic [7:0] rx_high;

  rx_result_t reply_q[$];   // results still owed by the block
  logic [7:0] char_q[$];    // characters waiting to be sent

  int sent_n;
  int taken_n;
  int err_count;
  int in_gap;
  int in_calm;
  int out_stall;
  int out_calm;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hex digit value, all ones when the character is not a hex digit
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 8'd10;
    if (c >= "A" && c <= "F") return c - "A" + 8'd10;
    return 8'hFF;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    logic [7:0] c;
    if (v < 4'd10) c = "0" + v;
    else c = (upper ? "A" : "a") + v - 8'd10;
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (digit_of(c) != 8'hFF);
    return c;
  endfunction

  // gap length: mostly none or short, a few long, with calm stretches of none
  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // advance the predicted receiver by one accepted character
  task automatic frame_rx_char(input logic [7:0] c);
    rx_result_t r;
    logic [7:0] sent_sum;
    case (rx_phase)
      RX_HUNT: begin
        if (c == CH_START) begin
          rx_sum   = 8'd0;
          rx_count = 0;
          rx_phase = RX_DATA;
        end
      end
      RX_DATA: begin
        if (c == CH_END) begin
          rx_phase = RX_CSUM_HI;
        end else begin
          r.kind      = KIND_BYTE;
          r.data_byte = c;
          r.position  = rx_count[POS_W-1:0];
          reply_q.push_back(r);
          rx_sum   = rx_sum + c;
          rx_count = rx_count + 1;
          // buffer full: drop the packet with no verdict
          if (rx_count + 1 >= BUF_SIZE) rx_phase = RX_HUNT;
        end
      end
      RX_CSUM_HI: begin
        rx_high  = digit_of(c) << 4;
        rx_phase = RX_CSUM_LO;
      end
      default: begin
        sent_sum = rx_high + digit_of(c);
        if (sent_sum == rx_sum) begin
          r.kind      = KIND_GOOD;
          r.data_byte = CH_ACK;
        end else begin
          r.kind      = KIND_BAD;
          r.data_byte = CH_NAK;
        end
        r.position = rx_count[POS_W-1:0];
        reply_q.push_back(r);
        rx_phase = RX_HUNT;
      end
    endcase
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
  endtask

  // one complete packet with random payload, no '#' inside it
  task automatic push_packet(input int len, input csum_style_t style);
    logic [7:0] sum;
    logic [7:0] b;
    bit         up;
    sum = 8'd0;
    up  = 1'($urandom_range(0, 1));
    char_q.push_back(CH_START);
    for (int i = 0; i < len; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_END);
      char_q.push_back(b);
      sum = sum + b;
    end
    char_q.push_back(CH_END);
    case (style)
      CS_GOOD: begin
        char_q.push_back(hex_char(sum[7:4], up));
        char_q.push_back(hex_char(sum[3:0], up));
      end
      CS_WRONG: begin
        b = sum ^ 8'($urandom_range(1, 255));
        char_q.push_back(hex_char(b[7:4], up));
        char_q.push_back(hex_char(b[3:0], up));
      end
      CS_BAD_HI: begin
        // matches when the sum's high nibble is all ones
        char_q.push_back(non_hex_char());
        char_q.push_back(hex_char(sum[3:0], up));
      end
      CS_BAD_LO: begin
        // a bad low digit borrows from the high one, matches when low nibble is F
        char_q.push_back(hex_char(sum[7:4] + 4'd1, up));
        char_q.push_back(non_hex_char());
      end
      default: begin
        char_q.push_back(non_hex_char());
        char_q.push_back(non_hex_char());
      end
    endcase
  endtask

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // sender and receiver, both change their signals on the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || taken_n == sent_n) begin
        if (in_gap > 0) begin
          in_gap--;
          s_tvalid <= 1'b0;
        end else if (char_q.size() != 0) begin
          s_tdata  <= char_q.pop_front();
          s_tvalid <= 1'b1;
          sent_n++;
          in_gap = pick_gap(in_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  // accepted characters feed the predictor, accepted results are checked
  always @(posedge clk) begin
    rx_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        taken_n++;
        frame_rx_char(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          report($sformatf("unexpected result kind %0d data %02h position %0d",
                           m_tuser, m_tdata[7:0], m_tdata[17:8]));
        end else begin
          want = reply_q.pop_front();
          if (m_tuser !== want.kind)
            report($sformatf("kind %0d, want %0d", m_tuser, want.kind));
          if (m_tdata[7:0] !== want.data_byte)
            report($sformatf("data_byte %02h, want %02h", m_tdata[7:0], want.data_byte));
          if (m_tdata[17:8] !== want.position)
            report($sformatf("position %0d, want %0d", m_tdata[17:8], want.position));
          if (m_tdata[23:18] !== 6'd0)
            report($sformatf("padding bits %02h not zero", m_tdata[23:18]));
        end
      end
    end
  end

  // cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    int len;
    int pick;
    logic [7:0] b;
    csum_style_t style;

    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 8'd0;
    m_tready    = 1'b0;
    rx_phase    = RX_HUNT;
    rx_sum      = 8'd0;
    rx_count    = 0;
    rx_high     = 8'd0;
    sent_n      = 0;
    taken_n     = 0;
    err_count   = 0;
    in_gap      = 0;
    in_calm     = 0;
    out_stall   = 0;
    out_calm    = 0;
    idle_cycles = 0;

    // directed: stray characters while hunting, empty packet
    char_q.push_back(8'h00);
    char_q.push_back(8'hFF);
    push_str("#$#00");
    // extreme bytes and a '$' inside the payload
    push_str("$");
    char_q.push_back(8'h00);
    char_q.push_back(8'hFF);
    push_str("$#23");
    // both checksum digits non-hex still match a sum of EF
    push_str("$");
    char_q.push_back(8'hEF);
    push_str("#g/");
    // non-hex high digit against a sum with high nibble F
    push_str("$");
    char_q.push_back(8'hF3);
    push_str("#:3");
    // checksum mismatch
    push_str("$A#00");

    // payload one byte short of the buffer limit is kept, the trailing "#00" gives its verdict
    char_q.push_back(CH_START);
    for (int i = 0; i < BUF_SIZE - 2; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_END);
      char_q.push_back(b);
    end
    push_str("#00");

    // random: mostly well-formed packets, some noise and broken packets
    while (char_q.size() < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        pick = $urandom_range(0, 9);
        if (pick < 5) style = CS_GOOD;
        else if (pick < 7) style = CS_WRONG;
        else if (pick == 7) style = CS_BAD_HI;
        else if (pick == 8) style = CS_BAD_LO;
        else style = CS_BAD_BOTH;
        push_packet(len, style);
      end else if (r < 85) begin
        // line noise
        repeat ($urandom_range(1, 6)) char_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        // start mark followed by arbitrary bytes, possibly never closed
        char_q.push_back(CH_START);
        repeat ($urandom_range(0, 8)) char_q.push_back(8'($urandom_range(0, 255)));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (char_q.size() != 0 || taken_n != sent_n) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
